/* rtl/core/pid_pkg.sv */
// Shared types, constants and helpers of the PID step block.
`default_nettype none
package pid_pkg;

   localparam int FRAC_BITS = 16;

   localparam int DATA_W    = 32;
   localparam int B_W       = 32;
   localparam int A_W       = (34 + FRAC_BITS > 48) ? (34 + FRAC_BITS) : 48;
   localparam int PROD_W    = A_W + B_W;
   localparam int CNT_W     = $clog2(A_W);
   localparam int CSR_IDX_W = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_PROP_GAIN  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_INTEG_GAIN = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_DERIV_GAIN = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_OUT_MIN    = CSR_IDX_W'(3);
   localparam logic [CSR_IDX_W-1:0] CSR_OUT_MAX    = CSR_IDX_W'(4);

   localparam logic [63:0] TERM_LIM = 64'd1 << 61;

   typedef enum logic [0:0] {
      OP_STEP  = 1'b0,
      OP_CLEAR = 1'b1
   } oper_type;

   typedef enum logic [0:0] {
      MD_MUL = 1'b0,
      MD_DIV = 1'b1
   } md_op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INTEG,
      ST_LOW,
      ST_HIGH,
      ST_DERIV,
      ST_PTERM,
      ST_ITERM,
      ST_DTERM,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] prop_gain;
      logic signed [DATA_W-1:0] integ_gain;
      logic signed [DATA_W-1:0] deriv_gain;
      logic signed [DATA_W-1:0] out_min;
      logic signed [DATA_W-1:0] out_max;
   } cfg_type;

   typedef struct packed {
      logic             start;
      md_op_type        op;
      logic [A_W-1:0]   a;
      logic [B_W-1:0]   b;
   } md_cmd_type;

   typedef struct packed {
      logic              done;
      logic [PROD_W-1:0] res;
   } md_rsp_type;

   function automatic logic [63:0] mag64(input logic signed [63:0] v);
      return v[63] ? 64'(-v) : 64'(v);
   endfunction

   function automatic logic signed [47:0] sat48(input logic signed [63:0] v);
      if (v > 64'sh0000_7FFF_FFFF_FFFF) return 48'sh7FFF_FFFF_FFFF;
      if (v < 64'shFFFF_8000_0000_0000) return 48'sh8000_0000_0000;
      return v[47:0];
   endfunction

endpackage
`default_nettype wire

/* rtl/core/pid_if.sv */
// Request and response channel interfaces of the PID step block.
`default_nettype none
interface pid_req_if;
   logic               valid;
   logic               ready;
   logic               operation;
   logic signed [31:0] target;
   logic signed [31:0] measured;
   logic        [31:0] step_time;

   modport source (output valid, operation, target, measured, step_time, input ready);
   modport sink   (input valid, operation, target, measured, step_time, output ready);
endinterface

interface pid_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] drive;
   logic               clipped;
   logic               zero_step;

   modport source (output valid, drive, clipped, zero_step, input ready);
   modport sink   (input valid, drive, clipped, zero_step, output ready);
endinterface
`default_nettype wire

/* rtl/core/pid_csr.sv */
// Configuration register bank of the PID step block.
`default_nettype none
module pid_csr import pid_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DATA_W-1:0]    csr_wdata,
   output cfg_type              cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_PROP_GAIN:  cfg_in.prop_gain  = csr_wdata;
            CSR_INTEG_GAIN: cfg_in.integ_gain = csr_wdata;
            CSR_DERIV_GAIN: cfg_in.deriv_gain = csr_wdata;
            CSR_OUT_MIN:    cfg_in.out_min    = csr_wdata;
            CSR_OUT_MAX:    cfg_in.out_max    = csr_wdata;
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.prop_gain  <= '0;
         cfg_ff.integ_gain <= '0;
         cfg_ff.deriv_gain <= '0;
         cfg_ff.out_min    <= 32'sh8000_0000;
         cfg_ff.out_max    <= 32'sh7FFF_FFFF;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

/* rtl/core/pid_muldiv.sv */
// Shared radix-2 unsigned multiply / restoring divide unit.
`default_nettype none
module pid_muldiv import pid_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  md_cmd_type cmd,
   output md_rsp_type rsp
);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   md_op_type         mode_ff;
   logic [A_W-1:0]    a_ff, a_in;
   logic [B_W-1:0]    b_ff;
   logic [PROD_W-1:0] p_ff, p_in;
   logic [B_W-1:0]    rem_ff, rem_in;

   logic [B_W:0]      trial;
   logic [A_W:0]      add_x;
   logic [A_W:0]      add_y;
   logic              add_sub;
   logic [A_W:0]      sum;
   logic              ge;
   logic [CNT_W-1:0]  last_cnt;

   // one adder serves both operations
   always_comb begin
      trial = {rem_ff, a_ff[A_W-1]};
      if (mode_ff == MD_MUL) begin
         add_x   = {1'b0, p_ff[PROD_W-1:B_W]};
         add_y   = p_ff[0] ? {1'b0, a_ff} : '0;
         add_sub = 1'b0;
      end else begin
         add_x   = (A_W+1)'(trial);
         add_y   = (A_W+1)'(b_ff);
         add_sub = 1'b1;
      end
      sum      = add_x + (add_sub ? ~add_y : add_y) + (A_W+1)'(add_sub);
      ge       = ~sum[A_W];
      last_cnt = (mode_ff == MD_MUL) ? CNT_W'(B_W - 1) : CNT_W'(A_W - 1);
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      a_in    = a_ff;
      p_in    = p_ff;
      rem_in  = rem_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         a_in    = cmd.a;
         p_in    = {A_W'(0), cmd.b};
         rem_in  = '0;
      end else if (busy_ff) begin
         if (mode_ff == MD_MUL) begin
            p_in = {sum, p_ff[B_W-1:1]};
         end else begin
            rem_in = ge ? sum[B_W-1:0] : trial[B_W-1:0];
            a_in   = {a_ff[A_W-2:0], ge};
         end
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == last_cnt) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      a_ff   <= a_in;
      p_ff   <= p_in;
      rem_ff <= rem_in;
      if (cmd.start) begin
         mode_ff <= cmd.op;
         b_ff    <= cmd.b;
      end
   end

   assign rsp.done = done_ff;
   assign rsp.res  = (mode_ff == MD_MUL) ? p_ff : PROD_W'(a_ff);

   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      cmd.start |-> !busy_ff)
      else $error("muldiv started while busy");

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff)
      else $error("muldiv reported done while busy");

   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff)
      else $error("muldiv done held for more than one cycle");

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> cnt_ff <= last_cnt)
      else $error("muldiv iteration count out of range");

endmodule
`default_nettype wire

/* rtl/core/pid_controller_step_top.sv */
// Top level of the PID controller step block with integral clamp.
// One request computes one controller step (or clears the integral and previous
// error) and yields exactly one response. All multiplies and divides run through a single
// shared radix-2 multiply / divide unit under a small sequencer, so the block
// takes one request at a time: ready is high only while the sequencer is idle.
// A compute step runs err*step_time, then (integ_gain nonzero) the two clamp
// bounds out_min/integ_gain and out_max/integ_gain, then (step_time nonzero) the
// derivative division, then the three gain products. A clear skips all of
// these and goes straight to the done state. The finished result sits in an
// output register, so the next request is taken while the previous response
// still waits for its transfer. Configuration is written through csr_wr_en /
// csr_index / csr_wdata; indexes past out_max are ignored.
`default_nettype none
module pid_controller_step_top import pid_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   pid_req_if.sink              req_chan,
   pid_rsp_if.source            rsp_chan,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DATA_W-1:0]    csr_wdata
);

   cfg_type    cfg;
   md_cmd_type md_cmd;
   md_rsp_type md_rsp;

   state_type state_ff, state_in;
   logic      run_ff, run_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // per-item working registers
   logic signed [32:0] err_ff;
   logic signed [33:0] diff_ff;
   logic signed [32:0] last_ff;
   logic        [31:0] step_ff;
   logic signed [47:0] es_ff;
   logic signed [47:0] lo_ff;
   logic signed [47:0] deriv_ff;
   logic signed [63:0] acc_ff;
   logic               neg_ff;
   logic               neg_in;
   logic               zs_ff;
   logic               clear_ff;

   logic signed [31:0] drive_ff;
   logic               clipped_ff;
   logic               zstep_ff;

   logic               req_fire;
   logic               rsp_fire;
   logic               out_free;
   logic               out_load;
   logic signed [32:0] err_new;

   logic [PROD_W-1:0]  shifted;
   logic [63:0]        term_mag;
   logic signed [63:0] term;
   logic [63:0]        quot_mag;
   logic signed [63:0] quot;
   logic signed [47:0] q48;
   logic signed [47:0] es_add;
   logic signed [47:0] es_clamped;
   logic signed [63:0] lim_lo;
   logic signed [63:0] lim_hi;
   logic signed [31:0] drive_val;
   logic               clip_val;

   pid_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   pid_muldiv u_muldiv (
      .clock (clock),
      .reset (reset),
      .cmd   (md_cmd),
      .rsp   (md_rsp)
   );

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_fire       = req_chan.valid & req_chan.ready;
   assign rsp_fire       = rsp_valid_ff & rsp_chan.ready;
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign out_load       = (state_ff == ST_DONE) && out_free;
   assign err_new        = 33'(req_chan.target) - 33'(req_chan.measured);

   // sequencer: next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = (req_chan.operation == OP_CLEAR) ? ST_DONE : ST_INTEG;
            end
         end
         ST_INTEG: begin
            if (md_rsp.done) begin
               if (cfg.integ_gain != '0) state_in = ST_LOW;
               else                      state_in = zs_ff ? ST_PTERM : ST_DERIV;
            end
         end
         ST_LOW: begin
            if (md_rsp.done) state_in = ST_HIGH;
         end
         ST_HIGH: begin
            if (md_rsp.done) state_in = zs_ff ? ST_PTERM : ST_DERIV;
         end
         ST_DERIV: begin
            if (md_rsp.done) state_in = ST_PTERM;
         end
         ST_PTERM: begin
            if (md_rsp.done) state_in = ST_ITERM;
         end
         ST_ITERM: begin
            if (md_rsp.done) state_in = ST_DTERM;
         end
         ST_DTERM: begin
            if (md_rsp.done) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // sequencer: operands for the shared unit, by state
   always_comb begin
      md_cmd = '0;
      neg_in = 1'b0;
      unique case (state_ff)
         ST_INTEG: begin
            md_cmd.start = !run_ff;
            md_cmd.op    = MD_MUL;
            md_cmd.a     = A_W'(mag64(64'(err_ff)));
            md_cmd.b     = step_ff;
            neg_in       = err_ff[32];
         end
         ST_LOW: begin
            md_cmd.start = !run_ff;
            md_cmd.op    = MD_DIV;
            md_cmd.a     = A_W'(mag64(64'(cfg.out_min)) << FRAC_BITS);
            md_cmd.b     = B_W'(mag64(64'(cfg.integ_gain)));
            neg_in       = cfg.out_min[31] ^ cfg.integ_gain[31];
         end
         ST_HIGH: begin
            md_cmd.start = !run_ff;
            md_cmd.op    = MD_DIV;
            md_cmd.a     = A_W'(mag64(64'(cfg.out_max)) << FRAC_BITS);
            md_cmd.b     = B_W'(mag64(64'(cfg.integ_gain)));
            neg_in       = cfg.out_max[31] ^ cfg.integ_gain[31];
         end
         ST_DERIV: begin
            md_cmd.start = !run_ff;
            md_cmd.op    = MD_DIV;
            md_cmd.a     = A_W'(mag64(64'(diff_ff)) << FRAC_BITS);
            md_cmd.b     = step_ff;
            neg_in       = diff_ff[33];
         end
         ST_PTERM: begin
            md_cmd.start = !run_ff;
            md_cmd.op    = MD_MUL;
            md_cmd.a     = A_W'(mag64(64'(err_ff)));
            md_cmd.b     = B_W'(mag64(64'(cfg.prop_gain)));
            neg_in       = err_ff[32] ^ cfg.prop_gain[31];
         end
         ST_ITERM: begin
            md_cmd.start = !run_ff;
            md_cmd.op    = MD_MUL;
            md_cmd.a     = A_W'(mag64(64'(es_ff)));
            md_cmd.b     = B_W'(mag64(64'(cfg.integ_gain)));
            neg_in       = es_ff[47] ^ cfg.integ_gain[31];
         end
         ST_DTERM: begin
            md_cmd.start = !run_ff;
            md_cmd.op    = MD_MUL;
            md_cmd.a     = A_W'(mag64(64'(deriv_ff)));
            md_cmd.b     = B_W'(mag64(64'(cfg.deriv_gain)));
            neg_in       = deriv_ff[47] ^ cfg.deriv_gain[31];
         end
         default: begin
            md_cmd = '0;
            neg_in = 1'b0;
         end
      endcase
   end

   // run flag: set when an operation is launched, drop when it reports done
   always_comb begin
      run_in = run_ff;
      if (md_cmd.start)    run_in = 1'b1;
      else if (md_rsp.done) run_in = 1'b0;
   end

   // post-processing of the shared unit's result
   always_comb begin
      shifted  = md_rsp.res >> FRAC_BITS;
      term_mag = (shifted > PROD_W'(TERM_LIM)) ? TERM_LIM : 64'(shifted);
      term     = neg_ff ? -$signed(term_mag) : $signed(term_mag);
      quot_mag = 64'(md_rsp.res[A_W-1:0]);
      quot     = neg_ff ? -$signed(quot_mag) : $signed(quot_mag);
      q48      = sat48(quot);
      es_add   = sat48(64'(es_ff) + term);

      // lower bound is checked first: with inverted bounds, a value below it takes it, else the upper
      if (es_ff < lo_ff)    es_clamped = lo_ff;
      else if (es_ff > q48) es_clamped = q48;
      else                  es_clamped = es_ff;

      lim_lo = 64'(cfg.out_min);
      lim_hi = 64'(cfg.out_max);
      if (acc_ff < lim_lo) begin
         drive_val = cfg.out_min;
         clip_val  = 1'b1;
      end else if (acc_ff > lim_hi) begin
         drive_val = cfg.out_max;
         clip_val  = 1'b1;
      end else begin
         drive_val = acc_ff[31:0];
         clip_val  = 1'b0;
      end
   end

   // response valid: hold until transfer, reload from the done state
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load)      rsp_valid_in = 1'b1;
      else if (rsp_fire) rsp_valid_in = 1'b0;
   end

   // control state and the controller's persistent state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         run_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         es_ff        <= '0;
         last_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         run_ff       <= run_in;
         rsp_valid_ff <= rsp_valid_in;
         if (req_fire) begin
            if (req_chan.operation == OP_CLEAR) begin
               es_ff   <= '0;
               last_ff <= '0;
            end else begin
               last_ff <= err_new;
            end
         end else if (md_rsp.done) begin
            if (state_ff == ST_INTEG)     es_ff <= es_add;
            else if (state_ff == ST_HIGH) es_ff <= es_clamped;
         end
      end
   end

   // working and result registers
   always_ff @(posedge clock) begin
      if (md_cmd.start) neg_ff <= neg_in;
      if (req_fire) begin
         clear_ff <= (req_chan.operation == OP_CLEAR);
         err_ff   <= err_new;
         diff_ff  <= 34'(err_new) - 34'(last_ff);
         step_ff  <= req_chan.step_time;
         zs_ff    <= (req_chan.step_time == '0);
         deriv_ff <= '0;
      end else if (md_rsp.done) begin
         unique case (state_ff)
            ST_LOW:   lo_ff    <= q48;
            ST_DERIV: deriv_ff <= q48;
            ST_PTERM: acc_ff   <= term;
            ST_ITERM: acc_ff   <= acc_ff + term;
            ST_DTERM: acc_ff   <= acc_ff - term;
            default:  acc_ff   <= acc_ff;
         endcase
      end
      if (out_load) begin
         drive_ff   <= clear_ff ? '0 : drive_val;
         clipped_ff <= clear_ff ? 1'b0 : clip_val;
         zstep_ff   <= clear_ff ? 1'b0 : zs_ff;
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.drive     = drive_ff;
   assign rsp_chan.clipped   = clipped_ff;
   assign rsp_chan.zero_step = zstep_ff;

   a_done_in_op: assert property (@(posedge clock) disable iff (reset)
      md_rsp.done |-> (state_ff != ST_IDLE && state_ff != ST_DONE))
      else $error("unit reported done outside an operation state");

   a_step_starts: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_chan.operation != OP_CLEAR) |=> state_ff == ST_INTEG)
      else $error("compute request did not enter integral update");

   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !run_ff)
      else $error("unit operation pending while idle");

   a_clear_state: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_chan.operation == OP_CLEAR) |=> (es_ff == '0 && last_ff == '0))
      else $error("clear did not zero controller state");

endmodule
`default_nettype wire

/* sim/pid_controller_step_top_tb.sv */
// Testbench for the PID controller step block: random and directed steps checked against a predictor.
`timescale 1ns / 1ps
`default_nettype none
module pid_controller_step_top_tb import pid_pkg::*; ();

   localparam int WATCHDOG_LIMIT = 20000;

   // One expected response of the block.
   typedef struct {
      logic signed [31:0] drive;
      logic               clipped;
      logic               zero_step;
   } pid_result_type;

   // Scoreboard: holds the controller state and settings, and the queue of
   // expected responses.
   class pid_scoreboard;
      longint         prop_gain, integ_gain, deriv_gain, out_min, out_max;
      longint         error_sum, last_error;
      pid_result_type pending[$];
      int             fail_count;

      function void clear_all();
         prop_gain = 0; integ_gain = 0; deriv_gain = 0;
         out_min = -(64'sd1 <<< 31); out_max = (64'sd1 <<< 31) - 1;
         error_sum = 0; last_error = 0;
         pending.delete();
         fail_count = 0;
      endfunction

      function void set_reg(logic [CSR_IDX_W-1:0] idx, logic [31:0] val);
         longint v;
         v = longint'(signed'(val));
         case (idx)
            CSR_PROP_GAIN:  prop_gain = v;
            CSR_INTEG_GAIN: integ_gain = v;
            CSR_DERIV_GAIN: deriv_gain = v;
            CSR_OUT_MIN:    out_min = v;
            CSR_OUT_MAX:    out_max = v;
            default: ;
         endcase
      endfunction

      function longint clip48(longint v);
         longint hi, lo;
         hi = (64'sd1 <<< 47) - 1;
         lo = -(64'sd1 <<< 47);
         if (v > hi) return hi;
         if (v < lo) return lo;
         return v;
      endfunction

      // Fixed-point product, truncated toward zero, magnitude capped at 2^61.
      function longint fx_mul(longint a, longint b);
         logic [127:0] p;
         logic [127:0] r;
         logic [63:0]  ua, ub;
         logic         neg;
         neg = (a < 0) != (b < 0);
         ua = (a < 0) ? 64'(-a) : 64'(a);
         ub = (b < 0) ? 64'(-b) : 64'(b);
         p = {64'd0, ua} * {64'd0, ub};
         r = p >> FRAC_BITS;
         if (r > 128'(TERM_LIM)) r = 128'(TERM_LIM);
         return neg ? -longint'(r[63:0]) : longint'(r[63:0]);
      endfunction

      // Note an accepted request and queue the response it must produce.
      function void note_request(logic op, logic [31:0] tgt, logic [31:0] meas,
                                 logic [31:0] dt);
         pid_result_type res;
         longint         err, deriv, drv, lo, hi, scale, step;
         scale = 64'sd1 <<< FRAC_BITS;
         step  = longint'({32'd0, dt});
         if (op == OP_CLEAR) begin
            error_sum = 0; last_error = 0;
            res.drive = 0; res.clipped = 0; res.zero_step = 0;
            pending.push_back(res);
            return;
         end
         err = longint'(signed'(tgt)) - longint'(signed'(meas));
         error_sum = clip48(error_sum + fx_mul(err, step));
         if (integ_gain != 0) begin
            lo = clip48((out_min * scale) / integ_gain);
            hi = clip48((out_max * scale) / integ_gain);
            if (error_sum < lo) error_sum = lo;
            else if (error_sum > hi) error_sum = hi;
         end
         res.zero_step = (step == 0);
         deriv = (step == 0) ? 0 : clip48(((err - last_error) * scale) / step);
         last_error = err;
         drv = fx_mul(prop_gain, err) + fx_mul(integ_gain, error_sum)
             - fx_mul(deriv_gain, deriv);
         res.clipped = 1;
         if (drv < out_min) drv = out_min;
         else if (drv > out_max) drv = out_max;
         else res.clipped = 0;
         res.drive = drv[31:0];
         pending.push_back(res);
      endfunction

      // Compare a transferred response with the oldest expectation.
      function void check_response(logic [31:0] drv, logic clp, logic zs);
         pid_result_type exp_res;
         if (pending.size() == 0) begin
            $error("unexpected response drive=%0d", signed'(drv));
            fail_count++;
            return;
         end
         exp_res = pending.pop_front();
         if (exp_res.drive !== drv) begin
            $error("drive: expected %0d, actual %0d", exp_res.drive, signed'(drv));
            fail_count++;
         end
         if (exp_res.clipped !== clp) begin
            $error("clipped: expected %0b, actual %0b", exp_res.clipped, clp);
            fail_count++;
         end
         if (exp_res.zero_step !== zs) begin
            $error("zero_step: expected %0b, actual %0b", exp_res.zero_step, zs);
            fail_count++;
         end
      endfunction
   endclass

   logic                 clock = 0;
   logic                 reset = 1;
   logic                 csr_wr_en = 0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_PROP_GAIN;
   logic [DATA_W-1:0]    csr_wdata = '0;
   int                   idle_cycles = 0;
   bit                   stim_done = 0;

   pid_req_if req_chan();
   pid_rsp_if rsp_chan();
   pid_scoreboard sb;

   pid_controller_step_top DUT (
      .clock(clock), .reset(reset),
      .req_chan(req_chan.sink), .rsp_chan(rsp_chan.source),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   initial begin
      req_chan.valid = 0;
      req_chan.operation = OP_STEP;
      req_chan.target = 0;
      req_chan.measured = 0;
      req_chan.step_time = 0;
      rsp_chan.ready = 0;
      sb = new();
      sb.clear_all();
   end

   // Monitor: note requests and check responses at each transfer.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_chan.valid && req_chan.ready)
            sb.note_request(req_chan.operation, req_chan.target,
                            req_chan.measured, req_chan.step_time);
         if (rsp_chan.valid && rsp_chan.ready)
            sb.check_response(rsp_chan.drive, rsp_chan.clipped, rsp_chan.zero_step);
      end
   end

   // Receiver stall pattern: cycle through calm, light-stall and heavy-stall stretches.
   always @(posedge clock) begin
      if (reset) rsp_chan.ready <= 0;
      else if (($time / 20000) % 3 == 0) rsp_chan.ready <= 1;
      else if (($time / 20000) % 3 == 1) rsp_chan.ready <= ($urandom_range(0, 3) != 0);
      else rsp_chan.ready <= ($urandom_range(0, 4) == 0);
   end

   // Watchdog: count cycles with no transfer on either channel and no register write.
   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)
          || reset || csr_wr_en)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Write one register; the block must be idle. The caller drops the enable.
   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [31:0] val);
      csr_wr_en <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      sb.set_reg(idx, val);
   endtask

   // Transfer one request; hold valid until the handshake completes.
   task automatic send_request(logic op, logic [31:0] tgt, logic [31:0] meas,
                               logic [31:0] dt);
      req_chan.valid     <= 1;
      req_chan.operation <= op;
      req_chan.target    <= tgt;
      req_chan.measured  <= meas;
      req_chan.step_time <= dt;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   task automatic drop_valid(int gap);
      if (gap > 0) begin
         req_chan.valid <= 0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Wait until every expected response has arrived, then let the block settle.
   task automatic drain();
      req_chan.valid <= 0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // Random 32-bit value biased toward extremes and small magnitudes.
   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 5))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return 32'($signed($urandom_range(0, 'h3_0000)) - 'h1_8000);
         3: return $urandom_range(0, 2) == 0 ? 32'd0 : 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [31:0] pick_step();
      case ($urandom_range(0, 5))
         0: return 32'd0;
         1: return 32'hFFFF_FFFF;
         2: return 32'd1;
         3: return $urandom_range(1, 'h2_0000);
         default: return $urandom;
      endcase
   endfunction

   // Load all five registers, then drop the write enable.
   task automatic load_settings(logic [31:0] kp, logic [31:0] ki, logic [31:0] kd,
                                logic [31:0] lo, logic [31:0] hi);
      write_reg(CSR_PROP_GAIN, kp);
      write_reg(CSR_INTEG_GAIN, ki);
      write_reg(CSR_DERIV_GAIN, kd);
      write_reg(CSR_OUT_MIN, lo);
      write_reg(CSR_OUT_MAX, hi);
      csr_wr_en <= 0;
   endtask

   task automatic run_random(int count);
      int burst;
      int sent;
      sent = 0;
      while (sent < count) begin
         burst = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         repeat (burst) begin
            send_request(($urandom_range(0, 15) == 0) ? OP_CLEAR : OP_STEP,
                         pick_value(), pick_value(), pick_step());
            sent++;
         end
         drop_valid($urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 300));
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: defaults, then field extremes, clear and zero step time.
      send_request(OP_STEP, 32'h0001_0000, 32'h0, 32'h0001_0000);
      drain();
      load_settings(32'h0001_0000, 32'h0000_8000, 32'h0000_4000,
                    32'hFFF0_0000, 32'h0010_0000);
      send_request(OP_STEP, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
      send_request(OP_STEP, 32'h8000_0000, 32'h7FFF_FFFF, 32'd1);
      send_request(OP_STEP, 32'h0002_0000, 32'h0001_0000, 32'd0);
      send_request(OP_CLEAR, 32'h1234_5678, 32'h8765_4321, 32'hFFFF_FFFF);
      send_request(OP_STEP, 32'h0, 32'h0, 32'd0);
      send_request(OP_STEP, 32'h0000_8000, 32'hFFFF_8000, 32'h0000_1000);
      drain();
      // Zero integral gain: no integral clamp.
      load_settings(32'h0002_0000, 32'h0, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
      send_request(OP_STEP, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000);
      send_request(OP_STEP, 32'h8000_0000, 32'h7FFF_FFFF, 32'd0);
      send_request(OP_STEP, 32'h0001_0000, 32'h0, 32'd1);
      drain();
      // Inverted limits and negative integral gain.
      load_settings(32'h7FFF_FFFF, 32'hFFFF_0000, 32'h7FFF_FFFF,
                    32'h0001_0000, 32'hFFFF_0000);
      send_request(OP_STEP, 32'h0000_0000, 32'h0000_0000, 32'h0001_0000);
      send_request(OP_STEP, 32'h0100_0000, 32'h0, 32'h0001_0000);
      send_request(OP_STEP, 32'hFF00_0000, 32'h0, 32'h0000_0100);
      drain();
      load_settings(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0);
      send_request(OP_STEP, 32'h0001_0000, 32'h0, 32'h0001_0000);
      send_request(OP_STEP, 32'h0, 32'h0, 32'h0);
      drain();

      // Random phases, each with fresh settings.
      repeat (8) begin
         case ($urandom_range(0, 2))
            0: load_settings(pick_value(), pick_value(), pick_value(),
                             pick_value(), pick_value());
            1: load_settings($urandom_range(0, 'h4_0000), $urandom_range(0, 'h1_0000),
                             $urandom_range(0, 'h1000), 32'hFF00_0000, 32'h0100_0000);
            default: load_settings($urandom, $urandom, $urandom, $urandom, $urandom);
         endcase
         run_random(120);
         drain();
      end

      if (sb.fail_count == 0 && sb.pending.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end
endmodule
`default_nettype wire

/* files.f */
rtl/core/pid_pkg.sv
rtl/core/pid_if.sv
rtl/core/pid_csr.sv
rtl/core/pid_muldiv.sv
rtl/core/pid_controller_step_top.sv
sim/pid_controller_step_top_tb.sv
